@@ rtl/binary_arithmetic_encoder_top_defines.svh @@
// Assertion macros shared by the encoder RTL.
// Simulation builds get concurrent assertions, synthesis builds get nothing.
`ifndef BINARY_ARITHMETIC_ENCODER_TOP_DEFINES_SVH
`define BINARY_ARITHMETIC_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BAE_ASSERT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bae assertion failed");

// Next-cycle implication
`define BAE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bae assertion failed");

`else

`define BAE_ASSERT(name, clk, rst, ante, cons)
`define BAE_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ rtl/bae_pkg.sv @@
`timescale 1ns / 1ps

package bae_pkg;

   // Coding parameters
   localparam int unsigned PRECISION     = 12;
   localparam logic [7:0]  PENDING_LIMIT = 8'd255;

   // Field widths
   localparam int unsigned PROB_W = 12;
   localparam int unsigned BND_W  = 32;
   localparam int unsigned PROD_W = BND_W + PROB_W;

   localparam logic [BND_W-1:0] PROB_LIMIT = BND_W'(1) << PRECISION;

   // Interval constants
   localparam logic [BND_W-1:0] LOW_RESET   = 32'h0000_0000;
   localparam logic [BND_W-1:0] HIGH_RESET  = 32'hFFFF_FFFF;
   localparam logic [BND_W-1:0] E3_LOW_TH   = 32'h4000_0000;
   localparam logic [BND_W-1:0] E3_HIGH_TH  = 32'hC000_0000;
   localparam logic [BND_W-1:0] E3_LOW_MASK = 32'h7FFF_FFFF;
   localparam logic [BND_W-1:0] E3_HIGH_SET = 32'h8000_0001;

   // Byte buffer for one item's output
   localparam int unsigned RES_DEPTH = 64;
   localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
   localparam int unsigned RES_CW    = RES_AW + 1;

   // Item kinds
   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MUL,
      SEQ_SPLIT,
      SEQ_NORM,
      SEQ_PEND,
      SEQ_UNDER,
      SEQ_FLUSH,
      SEQ_FCHK,
      SEQ_DONE,
      SEQ_WAIT
   } seq_state_type;

   typedef enum logic [1:0] {
      DR_IDLE,
      DR_READ,
      DR_LOAD,
      DR_SEND
   } drain_state_type;

   // Hand-over of a finished item from sequencer to drain
   typedef struct packed {
      logic              start;
      logic [RES_CW-1:0] count;
      logic              overflow;
   } batch_type;

endpackage

@@ rtl/bae_intf.sv @@
`timescale 1ns / 1ps

// Request channel: one encode or flush item per transfer
interface bae_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [bae_pkg::PROB_W-1:0] prob;
   logic                      symbol_bit;

   modport source (output valid, output kind, output prob, output symbol_bit, input ready);
   modport sink   (input valid, input kind, input prob, input symbol_bit, output ready);
endinterface

// Response channel: one archive byte per transfer
interface bae_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       pending_overflow;

   modport source (output valid, output out_byte, output last, output pending_overflow,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input pending_overflow,
                   output ready);
endinterface

@@ rtl/bae_ram.sv @@
`timescale 1ns / 1ps

module bae_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bae_seq.sv @@
`timescale 1ns / 1ps
`include "binary_arithmetic_encoder_top_defines.svh"

module bae_seq (
   input  logic                       clock,
   input  logic                       reset,
   bae_req_if.sink                    req_if,
   output logic                       wr_en,
   output logic [bae_pkg::RES_AW-1:0] wr_addr,
   output logic [7:0]                 wr_data,
   output bae_pkg::batch_type         batch,
   input  logic                       drain_done
);

   import bae_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [BND_W-1:0]   low_ff, low_in;
   logic [BND_W-1:0]   high_ff, high_in;
   logic [7:0]         pending_ff, pending_in;
   logic [7:0]         acc_ff, acc_in;
   logic [2:0]         bits_ff, bits_in;
   logic               overflow_ff, overflow_in;
   logic [PROB_W-1:0]  prob_ff, prob_in;
   logic               sym_ff, sym_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               pend_bit_ff, pend_bit_in;
   logic               ret_flush_ff, ret_flush_in;
   logic [RES_CW-1:0]  count_ff, count_in;

   logic               msb_equal;
   logic               e3_cond;
   logic               emit_valid;
   logic               emit_bit;
   logic [PROB_W-1:0]  p_eff;
   logic [BND_W-1:0]   span;
   logic [BND_W-1:0]   mid;
   logic [7:0]         pend_inc;
   logic               shift_phase;

   assign msb_equal   = (low_ff[BND_W-1] == high_ff[BND_W-1]);
   assign e3_cond     = (low_ff >= E3_LOW_TH) && (high_ff < E3_HIGH_TH);
   assign span        = high_ff - low_ff;
   assign mid         = low_ff + BND_W'(prod_ff >> PRECISION);
   assign pend_inc    = (pending_ff < PENDING_LIMIT) ? (pending_ff + 8'd1) : pending_ff;
   assign shift_phase = (state_ff == SEQ_NORM) || (state_ff == SEQ_UNDER);

   // Probability clamp: zero becomes one, out of range saturates
   always_comb begin
      p_eff = req_if.prob;
      if (p_eff == '0) begin
         p_eff = PROB_W'(1);
      end
      if (BND_W'(p_eff) >= PROB_LIMIT) begin
         p_eff = PROB_W'(PROB_LIMIT - BND_W'(1));
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_if.valid) begin
               state_in = (req_if.kind == KIND_FLUSH) ? SEQ_FLUSH : SEQ_MUL;
            end
         end
         SEQ_MUL:   state_in = SEQ_SPLIT;
         SEQ_SPLIT: state_in = SEQ_NORM;
         SEQ_NORM: begin
            if (!msb_equal) begin
               state_in = SEQ_UNDER;
            end else if (pending_ff != '0) begin
               state_in = SEQ_PEND;
            end
         end
         SEQ_PEND: begin
            if (pending_ff == 8'd1) begin
               state_in = ret_flush_ff ? SEQ_FCHK : SEQ_NORM;
            end
         end
         SEQ_UNDER: begin
            if (!e3_cond) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_FLUSH: state_in = (pending_ff != '0) ? SEQ_PEND : SEQ_FCHK;
         SEQ_FCHK:  state_in = (bits_ff == '0) ? SEQ_DONE : SEQ_FLUSH;
         SEQ_DONE:  state_in = SEQ_WAIT;
         SEQ_WAIT: begin
            if (drain_done) begin
               state_in = SEQ_IDLE;
            end
         end
         default:   state_in = SEQ_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_if.ready   = 1'b0;
      emit_valid     = 1'b0;
      emit_bit       = 1'b0;
      batch.start    = 1'b0;
      batch.count    = count_ff;
      batch.overflow = overflow_ff;
      case (state_ff)
         SEQ_IDLE: req_if.ready = !reset;
         SEQ_NORM: begin
            emit_valid = msb_equal;
            emit_bit   = high_ff[BND_W-1];
         end
         SEQ_PEND: begin
            emit_valid = 1'b1;
            emit_bit   = pend_bit_ff;
         end
         SEQ_FLUSH: begin
            emit_valid = 1'b1;
            emit_bit   = low_ff[BND_W-1];
         end
         SEQ_DONE: batch.start = 1'b1;
         default: ;
      endcase
   end

   // Interval datapath and bit packer
   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      pending_in   = pending_ff;
      acc_in       = acc_ff;
      bits_in      = bits_ff;
      overflow_in  = overflow_ff;
      prob_in      = prob_ff;
      sym_in       = sym_ff;
      prod_in      = prod_ff;
      pend_bit_in  = pend_bit_ff;
      ret_flush_in = ret_flush_ff;
      count_in     = count_ff;

      case (state_ff)
         SEQ_IDLE: begin
            if (req_if.valid) begin
               prob_in      = p_eff;
               sym_in       = req_if.symbol_bit;
               ret_flush_in = (req_if.kind == KIND_FLUSH);
               count_in     = '0;
            end
         end
         SEQ_MUL: prod_in = PROD_W'(span) * PROD_W'(prob_ff);
         SEQ_SPLIT: begin
            if (sym_ff) begin
               high_in = mid;
            end else begin
               low_in = mid + BND_W'(1);
            end
         end
         SEQ_NORM: begin
            if (msb_equal) begin
               pend_bit_in = ~high_ff[BND_W-1];
               low_in      = low_ff << 1;
               high_in     = (high_ff << 1) | BND_W'(1);
            end
         end
         SEQ_PEND: pending_in = pending_ff - 8'd1;
         SEQ_UNDER: begin
            if (e3_cond) begin
               pending_in = pend_inc;
               if (pend_inc >= PENDING_LIMIT) begin
                  overflow_in = 1'b1;
               end
               low_in  = (low_ff << 1) & E3_LOW_MASK;
               high_in = (high_ff << 1) | E3_HIGH_SET;
            end
         end
         SEQ_FLUSH: begin
            pend_bit_in = ~low_ff[BND_W-1];
            low_in      = low_ff << 1;
         end
         SEQ_FCHK: begin
            if (bits_ff == '0) begin
               low_in     = LOW_RESET;
               high_in    = HIGH_RESET;
               pending_in = '0;
            end
         end
         default: ;
      endcase

      // One output bit per cycle into the byte packer
      wr_en   = 1'b0;
      wr_addr = count_ff[RES_AW-1:0];
      wr_data = {acc_ff[6:0], emit_bit};
      if (emit_valid) begin
         acc_in  = {acc_ff[6:0], emit_bit};
         bits_in = bits_ff + 3'd1;
         if (bits_ff == 3'd7) begin
            wr_en    = 1'b1;
            acc_in   = '0;
            count_in = count_ff + RES_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_IDLE;
         low_ff      <= LOW_RESET;
         high_ff     <= HIGH_RESET;
         pending_ff  <= '0;
         acc_ff      <= '0;
         bits_ff     <= '0;
         overflow_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         pending_ff  <= pending_in;
         acc_ff      <= acc_in;
         bits_ff     <= bits_in;
         overflow_ff <= overflow_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prob_ff      <= prob_in;
      sym_ff       <= sym_in;
      prod_ff      <= prod_in;
      pend_bit_ff  <= pend_bit_in;
      ret_flush_ff <= ret_flush_in;
   end

   `BAE_ASSERT(a_no_write_idle, clock, reset, state_ff == SEQ_IDLE, !wr_en)
   `BAE_ASSERT(a_pending_limit, clock, reset, 1'b1, pending_ff <= PENDING_LIMIT)
   `BAE_ASSERT_NEXT(a_overflow_sticky, clock, reset, overflow_ff, overflow_ff)
   `BAE_ASSERT(a_bounds_order, clock, reset, shift_phase, low_ff <= high_ff)
   `BAE_ASSERT(a_buffer_room, clock, reset, wr_en, count_ff < RES_CW'(RES_DEPTH))

endmodule

@@ rtl/bae_drain.sv @@
`timescale 1ns / 1ps

module bae_drain (
   input  logic                       clock,
   input  logic                       reset,
   input  bae_pkg::batch_type         batch,
   output logic                       drain_done,
   output logic [bae_pkg::RES_AW-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   bae_rsp_if.source                  rsp_if
);

   import bae_pkg::*;

   drain_state_type    state_ff, state_in;
   logic [RES_CW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RES_CW-1:0]  count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;
   logic               xfer;

   assign xfer = rsp_if.valid && rsp_if.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DR_IDLE: begin
            if (batch.start && (batch.count != '0)) begin
               state_in = DR_READ;
            end
         end
         DR_READ: state_in = DR_LOAD;
         DR_LOAD: state_in = DR_SEND;
         DR_SEND: begin
            if (xfer) begin
               state_in = last_ff ? DR_IDLE : DR_READ;
            end
         end
         default: state_in = DR_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      rsp_if.valid            = (state_ff == DR_SEND);
      rsp_if.out_byte         = byte_ff;
      rsp_if.last             = last_ff;
      rsp_if.pending_overflow = ovf_ff;
      rd_addr                 = rd_ptr_ff[RES_AW-1:0];
      drain_done              = done_ff;
   end

   // Read pointer, output register and completion pulse
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      done_in   = 1'b0;
      case (state_ff)
         DR_IDLE: begin
            if (batch.start) begin
               rd_ptr_in = '0;
               count_in  = batch.count;
               ovf_in    = batch.overflow;
               done_in   = (batch.count == '0);
            end
         end
         DR_LOAD: begin
            byte_in = rd_data;
            last_in = (rd_ptr_ff == (count_ff - RES_CW'(1)));
         end
         DR_SEND: begin
            if (xfer) begin
               rd_ptr_in = rd_ptr_ff + RES_CW'(1);
               done_in   = last_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      count_ff  <= count_in;
      ovf_ff    <= ovf_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

endmodule

@@ rtl/binary_arithmetic_encoder_top.sv @@
`timescale 1ns / 1ps
// Binary arithmetic encoder, 32-bit carry-less interval.
// req_if carries one item per transfer: kind 0 encodes symbol_bit with
// probability prob (scaled by 2^12, zero read as one), kind 1 pads the stream
// out to a byte boundary and restarts the interval.
// rsp_if carries the archive bytes an item completes, first bit in the MSB;
// last marks the item's final byte, pending_overflow is the sticky flag as it
// stands after that item. An item that completes no byte gives no transfer.
// One item is worked at a time; ready is high only while the sequencer idles.
// Encode: the item is accepted, multiplied and split, then the shift unit
// emits each output bit (each shifted-out bit and each pending bit) and does
// each underflow shift; two end checks and the hand-over follow, then each
// byte passes through the byte buffer. A flush: the item is accepted, each
// bit is emitted with one check per pass, then the hand-over and the bytes.
// The shift unit works one bit per cycle; the buffer read is registered.
// Ready rises once the last byte's transfer, or the hand-over when no byte is
// produced, has raised drain_done and the sequencer has left its wait state.
// A stalled receiver holds the current byte on rsp_if; nothing is dropped.
// Synchronous reset restores the full interval and clears the flag.
module binary_arithmetic_encoder_top (
   input  logic        clock,
   input  logic        reset,
   bae_req_if.sink     req_if,
   bae_rsp_if.source   rsp_if
);

   import bae_pkg::*;

   logic               wr_en;
   logic [RES_AW-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [RES_AW-1:0]  rd_addr;
   logic [7:0]         rd_data;
   batch_type          batch;
   logic               drain_done;

   // Interval sequencer and bit packer
   bae_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .batch      (batch),
      .drain_done (drain_done)
   );

   // Per-item byte buffer
   bae_ram #(
      .WIDTH (8),
      .DEPTH (RES_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Byte output stage
   bae_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .drain_done (drain_done),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_if     (rsp_if)
   );

endmodule
